/* src/pph_pkg.sv */
// ----------------------------------------------------------------------------
// pph_pkg
// Shared defaults and fixed widths of the persistent peak hold unit.
// ----------------------------------------------------------------------------
package pph_pkg;

    // Default window depth and sample width
    localparam int DEF_MAX_WINDOW  = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Width of the persistence length write data
    localparam int LEN_CFG_W = 5;

    // Item commands
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

endpackage

/* src/pph_window_ram.sv */
// ----------------------------------------------------------------------------
// pph_window_ram
// Sample window store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pph_window_ram #(
    parameter int MAX_WINDOW  = pph_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = pph_pkg::DEF_SAMPLE_BITS,
    parameter int ADDR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic signed [SAMPLE_BITS-1:0] rd_data
);

    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/persistent_peak_hold_unit.sv */
// ----------------------------------------------------------------------------
// persistent_peak_hold_unit
// Persistent min/max hold over a configurable ring window of signed samples.
// ----------------------------------------------------------------------------
// Each push transaction writes its sample into a ring window of persist_len
// entries (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW). Until
// the window is full the held values do not move. Once full, every push scans
// the window: the first full window seeds min_held with the window's largest
// value and max_held with its smallest; later the max only rises to the
// window's smallest value and the min only falls to its largest, so a new
// extreme must persist across the whole window. A clear transaction zeroes
// the fill state, the flag and both extremes. Every transaction returns one
// result with the current extremes and has_data. Writing persist_len restarts
// the window fill but keeps the held values; write it only while idle.
// Sequence: a push on a full window runs a scan that reads one window
// entry per cycle through the single RAM read port into one min/max compare
// unit, then waits out the registered read data, takes an update step and a
// result step, and returns to the idle state that accepts the next
// transaction. A clear or a push before the window is full goes from the
// idle state straight to the result state and back. Input is accepted only
// in the idle state; a finished result waits in the output register, so the
// next transaction can be accepted before the previous result is taken. The
// result state holds while that register is still full.
// ----------------------------------------------------------------------------
module persistent_peak_hold_unit #(
    parameter int MAX_WINDOW  = pph_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = pph_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [pph_pkg::LEN_CFG_W-1:0]   cfg_wr_data,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic signed [SAMPLE_BITS-1:0]   s_sample,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_BITS-1:0]   m_min_held,
    output logic signed [SAMPLE_BITS-1:0]   m_max_held,
    output logic                            m_has_data
);

    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (LEN_W > pph_pkg::LEN_CFG_W) ? LEN_W : pph_pkg::LEN_CFG_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic [ADDR_W-1:0]             wp_reg, wp_next;
    logic [LEN_W-1:0]              fill_reg, fill_next;
    logic                          seeded_reg, seeded_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    // scan unit
    logic [LEN_W-1:0]              idx_reg, idx_next;
    logic                          pend_reg, pend_next;
    logic                          first_reg, first_next;
    logic signed [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic signed [SAMPLE_BITS-1:0] hi_reg, hi_next;
    // output register
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_min_reg, m_min_next;
    logic signed [SAMPLE_BITS-1:0] m_max_reg, m_max_next;
    logic                          m_flag_reg, m_flag_next;

    logic                          in_xact;
    logic                          ram_wr_en;
    logic [ADDR_W-1:0]             wp_eff;
    logic [LEN_W-1:0]              wp_inc;
    logic [LEN_W-1:0]              fill_inc;
    logic                          issue;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic [CMP_W-1:0]              cfg_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_xact = s_valid && s_ready;
    assign ram_wr_en = in_xact && (s_cmd == pph_pkg::CMD_PUSH);

    // ring pointer: wrap on the effective length
    assign wp_eff   = (LEN_W'(wp_reg) >= len_reg) ? '0 : wp_reg;
    assign wp_inc   = LEN_W'(wp_eff) + LEN_W'(1);
    assign fill_inc = (fill_reg < len_reg) ? fill_reg + LEN_W'(1) : fill_reg;
    assign issue    = (idx_reg < len_reg);
    assign cfg_ext  = CMP_W'(cfg_wr_data);

    pph_window_ram #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_eff),
        .wr_data (s_sample),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        seeded_next  = seeded_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        first_next   = first_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        m_valid_next = m_valid_reg;
        m_min_next   = m_min_reg;
        m_max_next   = m_max_reg;
        m_flag_next  = m_flag_reg;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // length write: clamp to 1..MAX_WINDOW and restart the fill
        if (cfg_wr_en) begin
            if (cfg_ext == '0) begin
                len_next = LEN_W'(1);
            end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
                len_next = LEN_W'(MAX_WINDOW);
            end else begin
                len_next = LEN_W'(cfg_ext);
            end
            wp_next   = '0;
            fill_next = '0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xact) begin
                    if (s_cmd == pph_pkg::CMD_CLEAR) begin
                        wp_next     = '0;
                        fill_next   = '0;
                        seeded_next = 1'b0;
                        min_next    = '0;
                        max_next    = '0;
                        state_next  = ST_OUT;
                    end else begin
                        wp_next   = (wp_inc == len_reg) ? '0 : wp_inc[ADDR_W-1:0];
                        fill_next = fill_inc;
                        if (fill_inc == len_reg) begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            first_next = 1'b1;
                            state_next = ST_SCAN;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // fold the entry read last cycle
                if (pend_reg) begin
                    if (first_reg) begin
                        lo_next = rd_data;
                        hi_next = rd_data;
                    end else begin
                        if (rd_data < lo_reg) begin
                            lo_next = rd_data;
                        end
                        if (rd_data > hi_reg) begin
                            hi_next = rd_data;
                        end
                    end
                    first_next = 1'b0;
                end
                pend_next = issue;
                if (issue) begin
                    idx_next = idx_reg + LEN_W'(1);
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!seeded_reg) begin
                    min_next    = hi_reg;
                    max_next    = lo_reg;
                    seeded_next = 1'b1;
                end else begin
                    if (lo_reg > max_reg) begin
                        max_next = lo_reg;
                    end
                    if (hi_reg < min_reg) begin
                        min_next = hi_reg;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_min_next   = min_reg;
                    m_max_next   = max_reg;
                    m_flag_next  = seeded_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= LEN_W'(1);
            wp_reg      <= '0;
            fill_reg    <= '0;
            seeded_reg  <= 1'b0;
            min_reg     <= '0;
            max_reg     <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            seeded_reg  <= seeded_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        m_min_reg <= m_min_next;
        m_max_reg <= m_max_next;
        m_flag_reg <= m_flag_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_min_held = m_min_reg;
    assign m_max_held = m_max_reg;
    assign m_has_data = m_flag_reg;

    // fill count never passes the window length
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= len_reg)
        else $error("fill count exceeds window length");

    // seeded flag drops only on a clear transaction or after reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(seeded_reg) |-> ($past(in_xact && (s_cmd == pph_pkg::CMD_CLEAR))
                               || !$past(aresetn)))
        else $error("seeded flag dropped without clear");

    // a new result appears only out of the result state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside result state");

    // scan index never runs past the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg <= len_reg))
        else $error("scan index past window");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the persistent peak hold unit.
// ----------------------------------------------------------------------------
// A predictor that runs alongside the bench keeps its own ring window, fill
// count, flag and held extremes. It works out the result of every accepted
// input transaction, and the result is queued for the checker. The checker
// pops one expectation per accepted result transaction and compares it field
// by field. The stimulus comes in several parts:
//  - directed: the default length from reset, the field extremes, clear on
//    a full window, persistence over a short window, a length rewrite
//    that keeps the held values, and a length of zero.
//  - random: phases with a new window length each, the out-of-range lengths
//    among them. Each phase sends drifting level-plus-noise samples with some
//    full-range, extreme and clear transactions mixed in.
// The sender runs in bursts with random gaps. The receiver stalls on its own
// pattern, which changes over the run.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW        = pph_pkg::DEF_SAMPLE_BITS;
    localparam int WIN_DEPTH = pph_pkg::DEF_MAX_WINDOW;
    localparam int LCW       = pph_pkg::LEN_CFG_W;
    // Settling time after a drain, enough for a full-window scan still in flight
    localparam int SETTLE_CYCLES = 2 * WIN_DEPTH + 8;
    localparam int RANDOM_ITEMS  = 1600;

    typedef struct packed {
        logic signed [SW-1:0] min_v;
        logic signed [SW-1:0] max_v;
        logic                 flag;
    } peak_result_t;

    // ------------------------------------------------------------------------
    // DUT ports: every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LCW-1:0]       cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_cmd       = pph_pkg::CMD_PUSH;
    logic signed [SW-1:0] s_sample    = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic signed [SW-1:0] m_min_held;
    logic signed [SW-1:0] m_max_held;
    logic                 m_has_data;

    persistent_peak_hold_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_held  (m_min_held),
        .m_max_held  (m_max_held),
        .m_has_data  (m_has_data)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor state (copy of what the block should hold)
    // ------------------------------------------------------------------------
    logic [LCW-1:0]       hold_len;
    logic signed [SW-1:0] ring [WIN_DEPTH];
    int unsigned          ring_pos;
    int unsigned          ring_fill;
    logic                 seeded_q;
    logic signed [SW-1:0] min_q;
    logic signed [SW-1:0] max_q;

    peak_result_t expected_peaks[$];
    int           error_count;
    int           burst_left;
    int           random_sent;

    task automatic log_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    function automatic void reset_predictor();
        hold_len  = 5'd1;
        ring_pos  = 0;
        ring_fill = 0;
        seeded_q  = 1'b0;
        min_q     = '0;
        max_q     = '0;
        foreach (ring[i]) ring[i] = '0;
    endfunction

    // Applies one accepted transaction to the predictor; returns the result
    function automatic peak_result_t predict_peaks(input logic cmd,
                                                   input logic signed [SW-1:0] smp);
        int unsigned          span;
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        bit                   scan;

        // 0 acts as 1, anything past the window depth saturates
        span = (hold_len == 0) ? 1 :
               (hold_len > WIN_DEPTH) ? WIN_DEPTH : int'(hold_len);
        scan = 1'b0;

        if (cmd == pph_pkg::CMD_CLEAR) begin
            // clear leaves the ring contents alone
            ring_pos  = 0;
            ring_fill = 0;
            seeded_q  = 1'b0;
            min_q     = '0;
            max_q     = '0;
        end else begin
            if (ring_pos >= span) ring_pos = 0;
            ring[ring_pos] = smp;
            ring_pos = (ring_pos + 1) % span;
            if (ring_fill < span) begin
                ring_fill++;
                scan = (ring_fill >= span);
            end else begin
                scan = 1'b1;
            end
        end

        if (scan) begin
            lo = ring[0];
            hi = ring[0];
            for (int i = 1; i < span; i++) begin
                if (ring[i] < lo) lo = ring[i];
                if (ring[i] > hi) hi = ring[i];
            end
            if (!seeded_q) begin
                // first full window: min from the largest, max from the smallest
                min_q    = hi;
                max_q    = lo;
                seeded_q = 1'b1;
            end else begin
                if (lo > max_q) max_q = lo;
                if (hi < min_q) min_q = hi;
            end
        end
        return '{min_v: min_q, max_v: max_q, flag: seeded_q};
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------------
    int ready_mode;
    int ready_left;
    int cyc;

    // The pattern changes every so often: fully open, coin flip, one in five,
    // and rare openings (long stalls)
    always @(posedge aclk) begin
        cyc++;
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 200);
        end
        ready_left--;
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= (cyc % 5 == 0);
            end
            default: begin
                m_ready <= ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    // Each accepted result transaction is matched against the oldest expectation
    always @(posedge aclk) begin
        peak_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_peaks.size() == 0) begin
                log_mismatch($sformatf("unexpected result min=%0d max=%0d flag=%0b",
                                       m_min_held, m_max_held, m_has_data));
            end else begin
                exp_r = expected_peaks.pop_front();
                if (m_min_held !== exp_r.min_v)
                    log_mismatch($sformatf("min_held got %0d exp %0d",
                                           m_min_held, exp_r.min_v));
                if (m_max_held !== exp_r.max_v)
                    log_mismatch($sformatf("max_held got %0d exp %0d",
                                           m_max_held, exp_r.max_v));
                if (m_has_data !== exp_r.flag)
                    log_mismatch($sformatf("has_data got %0b exp %0b",
                                           m_has_data, exp_r.flag));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Sends one transaction. Called at a rising edge and returns at the edge
    // where it was accepted. Valid stays high into the next call unless a gap
    // is taken, so back-to-back bursts never drop valid.
    task automatic send_txn(input logic cmd, input logic signed [SW-1:0] smp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 10);
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        expected_peaks.push_back(predict_peaks(cmd, smp));
    endtask

    // Holds off the sender until every expected result is back, then lets the
    // block settle. Whatever is still missing after the cap counts as a failure.
    task automatic wait_results_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_peaks.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        while (expected_peaks.size() != 0) begin
            log_mismatch("result never arrived");
            void'(expected_peaks.pop_front());
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only written while idle; the block restarts its fill, the predictor too
    task automatic write_persist_len(input logic [LCW-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        hold_len  = len;
        ring_pos  = 0;
        ring_fill = 0;
    endtask

    task automatic apply_reset();
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        reset_predictor();
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Length 1 from reset: the first push seeds the extremes, later pushes can move them at once
    task automatic test_default_length();
        send_txn(pph_pkg::CMD_PUSH, 16'sh7FFF);
        send_txn(pph_pkg::CMD_PUSH, -16'sh8000);
        send_txn(pph_pkg::CMD_PUSH, 16'sh7FFF);
        // clear ignores its sample field and zeroes the fill, the flag and both extremes
        send_txn(pph_pkg::CMD_CLEAR, 16'sh5A5A);
    endtask

    // Length 3: seeding, a rise of the max, no fall without persistence
    task automatic test_persistence_window();
        wait_results_drained();
        write_persist_len(5'd3);
        send_txn(pph_pkg::CMD_PUSH, 16'sd10);
        send_txn(pph_pkg::CMD_PUSH, 16'sd20);
        send_txn(pph_pkg::CMD_PUSH, 16'sd30);
        send_txn(pph_pkg::CMD_PUSH, 16'sd40);
        send_txn(pph_pkg::CMD_PUSH, -16'sd5);
        // clear on a full window, then a fresh fill
        send_txn(pph_pkg::CMD_PUSH, 16'sd7);
        send_txn(pph_pkg::CMD_CLEAR, -16'sd1);
        send_txn(pph_pkg::CMD_PUSH, -16'sd100);
        send_txn(pph_pkg::CMD_PUSH, -16'sd200);
        send_txn(pph_pkg::CMD_PUSH, -16'sd300);
    endtask

    // Length rewrite keeps the held values; a length of 0 behaves as 1
    task automatic test_length_rewrite();
        wait_results_drained();
        write_persist_len(5'd2);
        send_txn(pph_pkg::CMD_PUSH, -16'sd400);
        send_txn(pph_pkg::CMD_PUSH, -16'sd450);
        wait_results_drained();
        write_persist_len(5'd0);
        send_txn(pph_pkg::CMD_PUSH, 16'sh7FFF);
        send_txn(pph_pkg::CMD_PUSH, -16'sd1);
    endtask

    // Random phases, each with its own window length and noise level
    task automatic test_random_windows();
        logic [LCW-1:0]       fixed_lens [4] = '{5'd16, 5'd31, 5'd0, 5'd17};
        logic [LCW-1:0]       len;
        logic signed [SW-1:0] smp;
        int                   phase;
        int                   phase_items;
        int                   noise;
        int                   level;
        int                   v;
        int                   pick;

        phase = 0;
        level = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_results_drained();
            // the extremes first, then mostly in-range lengths
            if (phase < 4)
                len = fixed_lens[phase];
            else if ($urandom_range(0, 6) == 0)
                len = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
            else
                len = 5'($urandom_range(1, 16));
            write_persist_len(len);

            case ($urandom_range(0, 3))
                0: noise = 0;
                1: noise = 4;
                2: noise = 64;
                default: noise = 2000;
            endcase
            phase_items = $urandom_range(60, 140);

            for (int n = 0; n < phase_items; n++) begin
                // in phase 0, and at random later, the sender waits for every result mid-phase
                if (n == phase_items / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
                    wait_results_drained();

                // drifting level, with occasional jumps so extremes move
                if ($urandom_range(0, 49) == 0)
                    level = $urandom_range(0, 65535) - 32768;
                else
                    level = level + $urandom_range(0, 200) - 100;
                if (level > 32767) level = 32767;
                if (level < -32768) level = -32768;

                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    send_txn(pph_pkg::CMD_CLEAR, SW'($urandom_range(0, 65535)));
                end else begin
                    if (pick < 12) begin
                        smp = SW'($urandom_range(0, 65535));
                    end else if (pick < 17) begin
                        case ($urandom_range(0, 3))
                            0: smp = 16'sh7FFF;
                            1: smp = -16'sh8000;
                            2: smp = '0;
                            default: smp = -16'sd1;
                        endcase
                    end else begin
                        v = level + $urandom_range(0, 2 * noise) - noise;
                        if (v > 32767) v = 32767;
                        if (v < -32768) v = -32768;
                        smp = SW'(v);
                    end
                    send_txn(pph_pkg::CMD_PUSH, smp);
                end
                random_sent++;
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        error_count = 0;
        burst_left  = 0;
        random_sent = 0;
        ready_mode  = 0;
        ready_left  = 0;
        cyc         = 0;
        reset_predictor();

        apply_reset();
        test_default_length();
        test_persistence_window();
        test_length_rewrite();
        test_random_windows();
        wait_results_drained();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
